/* rtl/ssi_pkg.sv */
// ----------------------------------------------------------------------------
// ssi_pkg
// shared types and constants of the segment intersection pipeline
// ----------------------------------------------------------------------------
package ssi_pkg;

    // default coordinate width
    localparam int COORD_BITS_DEF = 16;

    // per-stage load enables, handed from the flow control to the datapath
    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
        logic en4;
    } t_pipe_ctl;

endpackage

/* rtl/segment_segment_intersect_unit.sv */
// ----------------------------------------------------------------------------
// segment_segment_intersect_unit
// orientation-based test of whether two 2d segments touch or cross
// ----------------------------------------------------------------------------
// Each item carries two segments as origin plus extent in signed integer
// coordinates of COORD_BITS bits; the unit returns one hit bit per item, set
// when the segments cross or touch, colinear overlap and point-like segments
// included. Arithmetic is exact throughout. The unit is a four-stage pipeline
// that takes one item every clock while the output side is not stalled:
// stage 1 forms the end points, stage 2 the cross-product operands and the
// bounding box checks, stage 3 the eight exact products, stage 4 the
// orientation signs and the hit decision, held in the output register.
// Stalls on the output side fill empty stages first, so bubbles are squeezed
// out and no item is lost or repeated.
// ----------------------------------------------------------------------------
module segment_segment_intersect_unit #(
    parameter int COORD_BITS = ssi_pkg::COORD_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input item channel
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic signed [COORD_BITS-1:0]   i_a_origin_x,
    input  logic signed [COORD_BITS-1:0]   i_a_origin_y,
    input  logic signed [COORD_BITS-1:0]   i_a_extent_x,
    input  logic signed [COORD_BITS-1:0]   i_a_extent_y,
    input  logic signed [COORD_BITS-1:0]   i_b_origin_x,
    input  logic signed [COORD_BITS-1:0]   i_b_origin_y,
    input  logic signed [COORD_BITS-1:0]   i_b_extent_x,
    input  logic signed [COORD_BITS-1:0]   i_b_extent_y,
    // result item channel
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_hit
);
    import ssi_pkg::*;

    // valid bit of each stage, stage 4 is the output register
    logic       r_v1, r_v2, r_v3, r_v4;
    t_pipe_ctl  w_ctl;

    // front-to-back datapath between the two halves
    logic signed [COORD_BITS-1:0] w_ex [4];
    logic signed [COORD_BITS-1:0] w_ey [4];
    logic signed [COORD_BITS+1:0] w_dx [4];
    logic signed [COORD_BITS+1:0] w_dy [4];
    logic        [3:0]            w_box;

    // a stage loads when it is empty or its item moves on in the same cycle
    always_comb begin
        w_ctl.en4 = !r_v4 || i_ready;
        w_ctl.en3 = !r_v3 || w_ctl.en4;
        w_ctl.en2 = !r_v2 || w_ctl.en3;
        w_ctl.en1 = !r_v1 || w_ctl.en2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_ctl.en1) r_v1 <= i_valid;
            if (w_ctl.en2) r_v2 <= r_v1;
            if (w_ctl.en3) r_v3 <= r_v2;
            if (w_ctl.en4) r_v4 <= r_v3;
        end
    end

    assign o_ready = w_ctl.en1;
    assign o_valid = r_v4;

    // end points, differences, box checks
    ssi_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_ctl        (w_ctl),
        .i_a_origin_x (i_a_origin_x),
        .i_a_origin_y (i_a_origin_y),
        .i_a_extent_x (i_a_extent_x),
        .i_a_extent_y (i_a_extent_y),
        .i_b_origin_x (i_b_origin_x),
        .i_b_origin_y (i_b_origin_y),
        .i_b_extent_x (i_b_extent_x),
        .i_b_extent_y (i_b_extent_y),
        .o_ex         (w_ex),
        .o_ey         (w_ey),
        .o_dx         (w_dx),
        .o_dy         (w_dy),
        .o_box        (w_box)
    );

    // products, orientation signs, hit
    ssi_cross #(
        .COORD_BITS (COORD_BITS)
    ) u_cross (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_ex   (w_ex),
        .i_ey   (w_ey),
        .i_dx   (w_dx),
        .i_dy   (w_dy),
        .i_box  (w_box),
        .o_hit  (o_hit)
    );

`ifndef SYNTHESIS
    // an empty first stage always takes an item
    a_empty_accepts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v1 |-> o_ready)
        else $error("first stage empty but input not ready");

    // a full pipeline with a stalled output accepts nothing
    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && r_v3 && r_v4 && !i_ready) |-> !o_ready)
        else $error("input taken while pipeline full and stalled");

    // an accepted item occupies stage 1 in the next cycle
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_v1)
        else $error("accepted item lost at stage 1");

    // with the output free, stage 3 moves into the output register
    a_advance_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && i_ready) |=> o_valid)
        else $error("item lost between stage 3 and output");
`endif

endmodule

/* rtl/ssi_front.sv */
// ----------------------------------------------------------------------------
// ssi_front
// stages 1 and 2: end points, cross-product operands and bounding box checks
// ----------------------------------------------------------------------------
module ssi_front #(
    parameter int COORD_BITS = 16
) (
    input  logic                           i_clk,
    input  ssi_pkg::t_pipe_ctl             i_ctl,
    input  logic signed [COORD_BITS-1:0]   i_a_origin_x,
    input  logic signed [COORD_BITS-1:0]   i_a_origin_y,
    input  logic signed [COORD_BITS-1:0]   i_a_extent_x,
    input  logic signed [COORD_BITS-1:0]   i_a_extent_y,
    input  logic signed [COORD_BITS-1:0]   i_b_origin_x,
    input  logic signed [COORD_BITS-1:0]   i_b_origin_y,
    input  logic signed [COORD_BITS-1:0]   i_b_extent_x,
    input  logic signed [COORD_BITS-1:0]   i_b_extent_y,
    output logic signed [COORD_BITS-1:0]   o_ex [4],
    output logic signed [COORD_BITS-1:0]   o_ey [4],
    output logic signed [COORD_BITS+1:0]   o_dx [4],
    output logic signed [COORD_BITS+1:0]   o_dy [4],
    output logic        [3:0]              o_box
);
    import ssi_pkg::*;

    localparam int W  = COORD_BITS;
    localparam int PW = COORD_BITS + 1;
    localparam int DW = COORD_BITS + 2;

    // stage 1 registers: points
    logic signed [PW-1:0] r_a0x, r_a0y, r_a1x, r_a1y;
    logic signed [PW-1:0] r_b0x, r_b0y, r_b1x, r_b1y;
    logic signed [W-1:0]  r_aex, r_aey, r_bex, r_bey;

    // stage 2 registers
    logic signed [W-1:0]  r_ex [4];
    logic signed [W-1:0]  r_ey [4];
    logic signed [DW-1:0] r_dx [4];
    logic signed [DW-1:0] r_dy [4];
    logic        [3:0]    r_box;

    logic signed [DW-1:0] n_dx [4];
    logic signed [DW-1:0] n_dy [4];
    logic        [3:0]    n_box;

    function automatic logic f_in_box(
        input logic signed [PW-1:0] px, input logic signed [PW-1:0] py,
        input logic signed [PW-1:0] qx, input logic signed [PW-1:0] qy,
        input logic signed [PW-1:0] rx, input logic signed [PW-1:0] ry
    );
        logic signed [PW-1:0] xlo, xhi, ylo, yhi;
        xlo = (px < rx) ? px : rx;
        xhi = (px < rx) ? rx : px;
        ylo = (py < ry) ? py : ry;
        yhi = (py < ry) ? ry : py;
        return (qx >= xlo) && (qx <= xhi) && (qy >= ylo) && (qy <= yhi);
    endfunction

    function automatic logic signed [DW-1:0] f_diff(
        input logic signed [PW-1:0] r, input logic signed [PW-1:0] q
    );
        return {r[PW-1], r} - {q[PW-1], q};
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_ctl.en1) begin
            r_a0x <= {i_a_origin_x[W-1], i_a_origin_x};
            r_a0y <= {i_a_origin_y[W-1], i_a_origin_y};
            r_a1x <= {i_a_origin_x[W-1], i_a_origin_x} + {i_a_extent_x[W-1], i_a_extent_x};
            r_a1y <= {i_a_origin_y[W-1], i_a_origin_y} + {i_a_extent_y[W-1], i_a_extent_y};
            r_b0x <= {i_b_origin_x[W-1], i_b_origin_x};
            r_b0y <= {i_b_origin_y[W-1], i_b_origin_y};
            r_b1x <= {i_b_origin_x[W-1], i_b_origin_x} + {i_b_extent_x[W-1], i_b_extent_x};
            r_b1y <= {i_b_origin_y[W-1], i_b_origin_y} + {i_b_extent_y[W-1], i_b_extent_y};
            r_aex <= i_a_extent_x;
            r_aey <= i_a_extent_y;
            r_bex <= i_b_extent_x;
            r_bey <= i_b_extent_y;
        end
    end

    // r - q terms of the four orientations
    always_comb begin
        n_dx[0] = f_diff(r_b0x, r_a1x);
        n_dy[0] = f_diff(r_b0y, r_a1y);
        n_dx[1] = f_diff(r_b1x, r_a1x);
        n_dy[1] = f_diff(r_b1y, r_a1y);
        n_dx[2] = f_diff(r_a0x, r_b1x);
        n_dy[2] = f_diff(r_a0y, r_b1y);
        n_dx[3] = f_diff(r_a1x, r_b1x);
        n_dy[3] = f_diff(r_a1y, r_b1y);
        n_box[0] = f_in_box(r_a0x, r_a0y, r_b0x, r_b0y, r_a1x, r_a1y);
        n_box[1] = f_in_box(r_a0x, r_a0y, r_b1x, r_b1y, r_a1x, r_a1y);
        n_box[2] = f_in_box(r_b0x, r_b0y, r_a0x, r_a0y, r_b1x, r_b1y);
        n_box[3] = f_in_box(r_b0x, r_b0y, r_a1x, r_a1y, r_b1x, r_b1y);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en2) begin
            r_ex[0] <= r_aex;
            r_ex[1] <= r_aex;
            r_ex[2] <= r_bex;
            r_ex[3] <= r_bex;
            r_ey[0] <= r_aey;
            r_ey[1] <= r_aey;
            r_ey[2] <= r_bey;
            r_ey[3] <= r_bey;
            r_dx    <= n_dx;
            r_dy    <= n_dy;
            r_box   <= n_box;
        end
    end

    assign o_ex  = r_ex;
    assign o_ey  = r_ey;
    assign o_dx  = r_dx;
    assign o_dy  = r_dy;
    assign o_box = r_box;

endmodule

/* rtl/ssi_cross.sv */
// ----------------------------------------------------------------------------
// ssi_cross
// stages 3 and 4: exact cross products, orientation signs and hit decision
// ----------------------------------------------------------------------------
module ssi_cross #(
    parameter int COORD_BITS = 16
) (
    input  logic                           i_clk,
    input  ssi_pkg::t_pipe_ctl             i_ctl,
    input  logic signed [COORD_BITS-1:0]   i_ex [4],
    input  logic signed [COORD_BITS-1:0]   i_ey [4],
    input  logic signed [COORD_BITS+1:0]   i_dx [4],
    input  logic signed [COORD_BITS+1:0]   i_dy [4],
    input  logic        [3:0]              i_box,
    output logic                           o_hit
);
    import ssi_pkg::*;

    localparam int PRW = 2 * COORD_BITS + 2;

    typedef enum logic [1:0] {
        OR_COLIN = 2'd0,
        OR_CW    = 2'd1,
        OR_CCW   = 2'd2
    } t_orient;

    logic signed [PRW-1:0] r_lhs [4];
    logic signed [PRW-1:0] r_rhs [4];
    logic        [3:0]     r_box;
    logic                  r_hit;

    logic signed [PRW-1:0] n_lhs [4];
    logic signed [PRW-1:0] n_rhs [4];
    t_orient               w_or  [4];
    logic                  n_hit;

    // one multiplier pair per orientation
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_lhs[k] = PRW'(i_ey[k]) * PRW'(i_dx[k]);
            n_rhs[k] = PRW'(i_ex[k]) * PRW'(i_dy[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en3) begin
            r_lhs <= n_lhs;
            r_rhs <= n_rhs;
            r_box <= i_box;
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            if (r_lhs[k] == r_rhs[k]) begin
                w_or[k] = OR_COLIN;
            end else if (r_lhs[k] > r_rhs[k]) begin
                w_or[k] = OR_CW;
            end else begin
                w_or[k] = OR_CCW;
            end
        end
        n_hit = ((w_or[0] != w_or[1]) && (w_or[2] != w_or[3]))
             || ((w_or[0] == OR_COLIN) && r_box[0])
             || ((w_or[1] == OR_COLIN) && r_box[1])
             || ((w_or[2] == OR_COLIN) && r_box[2])
             || ((w_or[3] == OR_COLIN) && r_box[3]);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en4) begin
            r_hit <= n_hit;
        end
    end

    assign o_hit = r_hit;

endmodule

/* tb/sv/ssi_hit_checker.sv */
// ----------------------------------------------------------------------------
// ssi_hit_checker
// predicts the hit bit of every accepted segment pair and checks the results
// ----------------------------------------------------------------------------
// Watches both channels of the segment intersection unit. Each accepted input
// item is run through an exact orientation test, and the predicted hit bit is
// queued. Each accepted result item is compared with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssi_hit_checker #(
    parameter int COORD_BITS = ssi_pkg::COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] a_origin_x,
    input  logic signed [COORD_BITS-1:0] a_origin_y,
    input  logic signed [COORD_BITS-1:0] a_extent_x,
    input  logic signed [COORD_BITS-1:0] a_extent_y,
    input  logic signed [COORD_BITS-1:0] b_origin_x,
    input  logic signed [COORD_BITS-1:0] b_origin_y,
    input  logic signed [COORD_BITS-1:0] b_extent_x,
    input  logic signed [COORD_BITS-1:0] b_extent_y,
    input  logic                         res_valid,
    input  logic                         res_ready,
    input  logic                         res_hit,
    output int                           fail_cnt,
    output int                           pending_cnt
);

    typedef enum logic [1:0] {
        ORIENT_COLINEAR,
        ORIENT_CW,
        ORIENT_CCW
    } t_orient;

    typedef struct {
        longint x;
        longint y;
    } t_point;

    typedef struct packed {
        int unsigned seq;
        logic        hit;
    } t_hit_expect;

    t_hit_expect expected_hits[$];
    int unsigned items_in  = 0;
    int          errors    = 0;

    // sign of the cross-product difference, products compared directly
    function automatic t_orient orientation(t_point p, t_point q, t_point r);
        longint lhs;
        longint rhs;
        lhs = (q.y - p.y) * (r.x - q.x);
        rhs = (q.x - p.x) * (r.y - q.y);
        if (lhs == rhs) begin
            return ORIENT_COLINEAR;
        end
        return (lhs > rhs) ? ORIENT_CW : ORIENT_CCW;
    endfunction

    // q inside the inclusive bounding box of p..r
    function automatic bit in_bbox(t_point p, t_point q, t_point r);
        longint xlo;
        longint xhi;
        longint ylo;
        longint yhi;
        xlo = (p.x < r.x) ? p.x : r.x;
        xhi = (p.x < r.x) ? r.x : p.x;
        ylo = (p.y < r.y) ? p.y : r.y;
        yhi = (p.y < r.y) ? r.y : p.y;
        return (q.x >= xlo) && (q.x <= xhi) && (q.y >= ylo) && (q.y <= yhi);
    endfunction

    function automatic logic predict_hit(longint ax, longint ay, longint aex, longint aey,
                                         longint bx, longint by, longint bex, longint bey);
        t_point  a0;
        t_point  a1;
        t_point  b0;
        t_point  b1;
        t_orient o1;
        t_orient o2;
        t_orient o3;
        t_orient o4;
        a0.x = ax;
        a0.y = ay;
        a1.x = ax + aex;
        a1.y = ay + aey;
        b0.x = bx;
        b0.y = by;
        b1.x = bx + bex;
        b1.y = by + bey;
        o1 = orientation(a0, a1, b0);
        o2 = orientation(a0, a1, b1);
        o3 = orientation(b0, b1, a0);
        o4 = orientation(b0, b1, a1);
        return ((o1 != o2) && (o3 != o4))
            || ((o1 == ORIENT_COLINEAR) && in_bbox(a0, b0, a1))
            || ((o2 == ORIENT_COLINEAR) && in_bbox(a0, b1, a1))
            || ((o3 == ORIENT_COLINEAR) && in_bbox(b0, a0, b1))
            || ((o4 == ORIENT_COLINEAR) && in_bbox(b0, a1, b1));
    endfunction

    always @(posedge clk) begin
        t_hit_expect head;
        if (rst_n) begin
            if (in_valid && in_ready) begin
                head.seq = items_in;
                head.hit = predict_hit(a_origin_x, a_origin_y, a_extent_x, a_extent_y,
                                       b_origin_x, b_origin_y, b_extent_x, b_extent_y);
                expected_hits.push_back(head);
                items_in++;
            end
            if (res_valid && res_ready) begin
                if (expected_hits.size() == 0) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("[%0t] result item with no pending prediction, hit=%b",
                                 $time, res_hit);
                    end
                end else begin
                    head = expected_hits.pop_front();
                    if (res_hit !== head.hit) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("[%0t] item %0d: hit expected %b, got %b",
                                     $time, head.seq, head.hit, res_hit);
                        end
                    end
                end
            end
        end
        fail_cnt    <= errors;
        pending_cnt <= expected_hits.size();
    end

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for the segment intersection unit
// ----------------------------------------------------------------------------
// Drives segment pairs into the unit: a short directed list of crossings,
// touches, colinear overlaps, point-like segments and extreme coordinates,
// then random pairs shaped to hit the colinear and touching corners often.
// The sender works in bursts with random gaps, the receiver stalls in
// changing patterns. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    import ssi_pkg::*;

    localparam int CB             = COORD_BITS_DEF;
    localparam int RANDOM_ITEMS   = 1500;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 12;

    typedef logic signed [CB-1:0] t_coord;

    // one input item: two segments as origin plus extent
    typedef struct packed {
        t_coord ax;
        t_coord ay;
        t_coord aex;
        t_coord aey;
        t_coord bx;
        t_coord by;
        t_coord bex;
        t_coord bey;
    } t_seg_pair;

    // shapes of random segment pairs
    typedef enum int {
        PAIR_NOISE,
        PAIR_EXTREME,
        PAIR_TINY,
        PAIR_COLINEAR,
        PAIR_POINT,
        PAIR_SHARED_END,
        PAIR_MEDIUM
    } t_pair_kind;

    // receiver stall patterns
    typedef enum int {
        RX_FREE,
        RX_COIN,
        RX_MOSTLY,
        RX_RUNS
    } t_rx_mode;

    // clock, reset and block inputs, all known from time zero
    logic   i_clk        = 1'b0;
    logic   i_rst_n      = 1'b0;
    logic   i_valid      = 1'b0;
    logic   i_ready      = 1'b0;
    t_coord i_a_origin_x = '0;
    t_coord i_a_origin_y = '0;
    t_coord i_a_extent_x = '0;
    t_coord i_a_extent_y = '0;
    t_coord i_b_origin_x = '0;
    t_coord i_b_origin_y = '0;
    t_coord i_b_extent_x = '0;
    t_coord i_b_extent_y = '0;

    // block outputs
    logic o_ready;
    logic o_valid;
    logic o_hit;

    // checker status
    int fail_cnt;
    int pending_cnt;

    // sender and watchdog bookkeeping
    int burst_left  = 0;
    int idle_cycles = 0;

    // receiver pattern state, private to the receiver process
    t_rx_mode rx_mode     = RX_FREE;
    int       rx_mode_left = 0;
    int       rx_run_left  = 0;
    logic     rx_run_level = 1'b1;

    segment_segment_intersect_unit #(
        .COORD_BITS (CB)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_a_origin_x (i_a_origin_x),
        .i_a_origin_y (i_a_origin_y),
        .i_a_extent_x (i_a_extent_x),
        .i_a_extent_y (i_a_extent_y),
        .i_b_origin_x (i_b_origin_x),
        .i_b_origin_y (i_b_origin_y),
        .i_b_extent_x (i_b_extent_x),
        .i_b_extent_y (i_b_extent_y),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_hit        (o_hit)
    );

    ssi_hit_checker #(
        .COORD_BITS (CB)
    ) u_hit_check (
        .clk         (i_clk),
        .rst_n       (i_rst_n),
        .in_valid    (i_valid),
        .in_ready    (o_ready),
        .a_origin_x  (i_a_origin_x),
        .a_origin_y  (i_a_origin_y),
        .a_extent_x  (i_a_extent_x),
        .a_extent_y  (i_a_extent_y),
        .b_origin_x  (i_b_origin_x),
        .b_origin_y  (i_b_origin_y),
        .b_extent_x  (i_b_extent_x),
        .b_extent_y  (i_b_extent_y),
        .res_valid   (o_valid),
        .res_ready   (i_ready),
        .res_hit     (o_hit),
        .fail_cnt    (fail_cnt),
        .pending_cnt (pending_cnt)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver: picks a new stall pattern whenever the current one runs out
    always @(posedge i_clk) begin
        if (rx_mode_left == 0) begin
            rx_mode      = t_rx_mode'($urandom_range(RX_FREE, RX_RUNS));
            rx_mode_left = $urandom_range(50, 300);
        end
        rx_mode_left--;
        case (rx_mode)
            RX_FREE: begin
                i_ready <= 1'b1;
            end
            RX_COIN: begin
                i_ready <= 1'($urandom_range(0, 1));
            end
            RX_MOSTLY: begin
                i_ready <= ($urandom_range(0, 9) != 0);
            end
            default: begin
                // alternating runs of ready and stall of random length
                if (rx_run_left == 0) begin
                    rx_run_left  = $urandom_range(1, 20);
                    rx_run_level = ~rx_run_level;
                end
                rx_run_left--;
                i_ready <= rx_run_level;
            end
        endcase
    end

    // watchdog: cycles with no accepted item on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    function automatic t_seg_pair seg_pair(int ax, int ay, int aex, int aey,
                                           int bx, int by, int bex, int bey);
        t_seg_pair p;
        p.ax  = t_coord'(ax);
        p.ay  = t_coord'(ay);
        p.aex = t_coord'(aex);
        p.aey = t_coord'(aey);
        p.bx  = t_coord'(bx);
        p.by  = t_coord'(by);
        p.bex = t_coord'(bex);
        p.bey = t_coord'(bey);
        return p;
    endfunction

    // uniform value in -lim..lim
    function automatic int srand(int lim);
        int v;
        v = $urandom_range(0, 2 * lim);
        return v - lim;
    endfunction

    function automatic t_seg_pair random_pair();
        int         corners[7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};
        int         v[8];
        int         px;
        int         py;
        int         dx;
        int         dy;
        int         ex;
        int         ey;
        int         sel;
        t_pair_kind kind;
        t_seg_pair  p;
        sel = $urandom_range(0, 99);
        if (sel < 10) begin
            kind = PAIR_NOISE;
        end else if (sel < 18) begin
            kind = PAIR_EXTREME;
        end else if (sel < 35) begin
            kind = PAIR_TINY;
        end else if (sel < 55) begin
            kind = PAIR_COLINEAR;
        end else if (sel < 70) begin
            kind = PAIR_POINT;
        end else if (sel < 85) begin
            kind = PAIR_SHARED_END;
        end else begin
            kind = PAIR_MEDIUM;
        end
        case (kind)
            PAIR_NOISE: begin
                foreach (v[i]) v[i] = $urandom;
            end
            PAIR_EXTREME: begin
                foreach (v[i]) v[i] = corners[$urandom_range(0, 6)];
            end
            PAIR_TINY: begin
                // tiny grid, colinear and touching cases are common
                foreach (v[i]) v[i] = srand(6);
            end
            PAIR_COLINEAR: begin
                // both segments on one line through (px,py) with step (dx,dy)
                px   = srand(20000);
                py   = srand(20000);
                dx   = srand(60);
                dy   = srand(60);
                v[0] = px + srand(40) * dx;
                v[1] = py;
                v[1] = v[1] + ((v[0] - px) / ((dx == 0) ? 1 : dx)) * dy;
                ex   = srand(40);
                v[2] = ex * dx;
                v[3] = ex * dy;
                sel  = srand(40);
                v[4] = px + sel * dx;
                v[5] = py + sel * dy;
                ex   = srand(40);
                v[6] = ex * dx;
                v[7] = ex * dy;
                if (dx == 0) begin
                    // vertical line, origin of a rebuilt on the line
                    sel  = srand(40);
                    v[0] = px;
                    v[1] = py + sel * dy;
                end
            end
            PAIR_POINT: begin
                // first segment collapsed to a point near or on the second
                v[4] = srand(10000);
                v[5] = srand(10000);
                ex   = srand(5000);
                ey   = srand(5000);
                v[6] = 2 * ex;
                v[7] = 2 * ey;
                case ($urandom_range(0, 3))
                    0: begin
                        v[0] = v[4];
                        v[1] = v[5];
                    end
                    1: begin
                        v[0] = v[4] + v[6];
                        v[1] = v[5] + v[7];
                    end
                    2: begin
                        v[0] = v[4] + ex;
                        v[1] = v[5] + ey;
                    end
                    default: begin
                        v[0] = v[4] + ex + srand(2);
                        v[1] = v[5] + ey + srand(2);
                    end
                endcase
                v[2] = 0;
                v[3] = 0;
                if ($urandom_range(0, 3) == 0) begin
                    v[6] = 0;
                    v[7] = 0;
                end
            end
            PAIR_SHARED_END: begin
                // second segment starts at an end point of the first
                v[0] = srand(16000);
                v[1] = srand(16000);
                v[2] = srand(16000);
                v[3] = srand(16000);
                if ($urandom_range(0, 1)) begin
                    v[4] = v[0] + v[2];
                    v[5] = v[1] + v[3];
                end else begin
                    v[4] = v[0];
                    v[5] = v[1];
                end
                v[6] = srand(16000);
                v[7] = srand(16000);
            end
            default: begin
                foreach (v[i]) v[i] = srand(1000);
            end
        endcase
        p = seg_pair(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]);
        // swap the roles of the segments half the time
        if ($urandom_range(0, 1)) begin
            p = seg_pair(p.bx, p.by, p.bex, p.bey, p.ax, p.ay, p.aex, p.aey);
        end
        return p;
    endfunction

    // present one item and hold it until accepted, with bursts and gaps
    task automatic send_pair(input t_seg_pair p);
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            // mostly short bursts, now and then a long stretch with no gap
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
        end
        i_valid      <= 1'b1;
        i_a_origin_x <= p.ax;
        i_a_origin_y <= p.ay;
        i_a_extent_x <= p.aex;
        i_a_extent_y <= p.aey;
        i_b_origin_x <= p.bx;
        i_b_origin_y <= p.by;
        i_b_extent_x <= p.bex;
        i_b_extent_y <= p.bey;
        do @(posedge i_clk); while (!o_ready);
        burst_left--;
    endtask

    // hold the sender off until every predicted result has come back
    task automatic wait_results_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_cnt != 0) @(posedge i_clk);
    endtask

    initial begin
        t_seg_pair directed[$];

        // crossing and near misses
        directed.push_back(seg_pair(0, 0, 10, 10, 0, 10, 10, -10));
        directed.push_back(seg_pair(0, 0, 10, 0, 0, 5, 10, 0));
        directed.push_back(seg_pair(-100, 50, 200, -100, -100, -50, 200, 100));
        // colinear overlap, gap and end-to-end touch
        directed.push_back(seg_pair(0, 0, 10, 0, 5, 0, 10, 0));
        directed.push_back(seg_pair(0, 0, 4, 0, 5, 0, 4, 0));
        directed.push_back(seg_pair(0, 0, 5, 0, 5, 0, 5, 0));
        directed.push_back(seg_pair(0, 0, 8, 8, 12, 12, -8, -8));
        // t-junction and its near miss
        directed.push_back(seg_pair(0, 0, 10, 0, 5, 0, 0, 7));
        directed.push_back(seg_pair(0, 0, 10, 0, 5, 1, 0, 7));
        // point-like segments: on, off, past the end, equal points, distinct points
        directed.push_back(seg_pair(3, 3, 0, 0, 0, 0, 6, 6));
        directed.push_back(seg_pair(3, 4, 0, 0, 0, 0, 6, 6));
        directed.push_back(seg_pair(9, 9, 0, 0, 0, 0, 6, 6));
        directed.push_back(seg_pair(7, -7, 0, 0, 7, -7, 0, 0));
        directed.push_back(seg_pair(7, -7, 0, 0, -7, 7, 0, 0));
        // extremes of every field
        directed.push_back(seg_pair(-32768, -32768, -32768, -32768,
                                    -32768, -32768, -32768, -32768));
        directed.push_back(seg_pair(32767, 32767, 32767, 32767,
                                    32767, 32767, 32767, 32767));
        directed.push_back(seg_pair(-32768, -32768, -32768, -32768,
                                    32767, 32767, 32767, 32767));
        directed.push_back(seg_pair(-32768, -32768, 32767, 32767,
                                    -32768, 32767, 32767, -32768));
        directed.push_back(seg_pair(32767, -32768, -32768, 32767,
                                    -32768, -32768, 32767, 32767));
        directed.push_back(seg_pair(0, 0, 32767, -32768, 0, 0, -32768, 32767));
        // alternating bit patterns
        directed.push_back(seg_pair(21845, -21846, -21846, 21845,
                                    -21846, 21845, 21845, -21846));

        // hold the synchronous reset, then release it
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) send_pair(directed[i]);
        wait_results_drained();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            // one full drain in the middle of the random part
            if (i == RANDOM_ITEMS / 2) begin
                wait_results_drained();
            end
            send_pair(random_pair());
        end

        // let the pipeline empty and catch any stray results
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
